[hw/rtl/vt_esc_pkg.sv]
// Shared types and constants for the terminal escape key decoder.
package vt_esc_pkg;

  localparam int unsigned KindW    = 4;
  localparam int unsigned CharW    = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned RunMax   = 3;
  localparam int unsigned RunCntW  = 2;

  localparam logic [TickW-1:0] TimeoutReset = 16'd12000;

  localparam logic [CharW-1:0] ChEsc     = 8'h1B;
  localparam logic [CharW-1:0] ChCsi     = 8'h5B;  // '['
  localparam logic [CharW-1:0] ChSs3     = 8'h4F;  // 'O'
  localparam logic [CharW-1:0] ChArrowLo = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChFuncLo  = 8'h50;  // 'P'
  localparam logic [CharW-1:0] ChNone    = 8'hFF;

  typedef enum logic [KindW-1:0] {
    KIND_PLAIN = 4'd0,
    KIND_ESC   = 4'd1,
    KIND_UP    = 4'd2,
    KIND_DOWN  = 4'd3,
    KIND_RIGHT = 4'd4,
    KIND_LEFT  = 4'd5,
    KIND_F1    = 4'd6,
    KIND_F2    = 4'd7,
    KIND_F3    = 4'd8,
    KIND_F4    = 4'd9
  } key_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2,
    PH_SS3  = 2'd3
  } phase_e;

  // One key event as it leaves the block.
  typedef struct packed {
    key_kind_e        kind;
    logic [CharW-1:0] code;
    logic             last;
  } key_ev_t;

  // All key events caused by one accepted beat.
  typedef struct packed {
    logic [RunCntW-1:0]       cnt;
    key_ev_t [RunMax-1:0]     ev;
  } key_run_t;

endpackage

[hw/rtl/vt_esc_decode.sv]
// Sequence state, timeout counter and the single-pass decode of one input beat.
module vt_esc_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic                         is_tick_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [15:0]                  timeout_i,
  output vt_esc_pkg::key_run_t         run_o
);
  import vt_esc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  wait_q, wait_d;
  logic [TickW-1:0]  wait_inc;
  logic [TickW-1:0]  limit;
  logic              tick;
  logic [CharW-1:0]  intro;
  logic [CharW-1:0]  first;
  logic [CharW-1:0]  offs;
  key_kind_e         base;
  key_run_t          run;

  function automatic key_ev_t mk_ev(key_kind_e kind, logic [CharW-1:0] code);
    key_ev_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.last = 1'b0;
    return ev;
  endfunction

  assign tick     = is_tick_i | (rx_byte_i == ChNone);
  assign wait_inc = wait_q + TickW'(1);
  assign limit    = (timeout_i == '0) ? TickW'(1) : timeout_i;
  assign intro    = (phase_q == PH_CSI) ? ChCsi : ChSs3;
  assign first    = (phase_q == PH_CSI) ? ChArrowLo : ChFuncLo;
  assign base     = (phase_q == PH_CSI) ? KIND_UP : KIND_F1;
  assign offs     = rx_byte_i - first;

  // Decode one beat against the current phase
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    run     = '0;
    if (tick) begin
      if (phase_q != PH_IDLE) begin
        wait_d = wait_inc;
        if (wait_inc >= limit) begin
          run.ev[0] = mk_ev(KIND_ESC, '0);
          run.cnt   = RunCntW'(1);
          phase_d   = PH_IDLE;
          wait_d    = '0;
        end
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == ChEsc) begin
            phase_d = PH_ESC;
            wait_d  = '0;
          end else begin
            run.ev[0] = mk_ev(KIND_PLAIN, rx_byte_i);
            run.cnt   = RunCntW'(1);
          end
        end
        PH_ESC: begin
          wait_d = '0;
          if (rx_byte_i == ChCsi) begin
            phase_d = PH_CSI;
          end else if (rx_byte_i == ChSs3) begin
            phase_d = PH_SS3;
          end else begin
            run.ev[0] = mk_ev(KIND_ESC, '0);
            run.ev[1] = mk_ev(KIND_PLAIN, rx_byte_i);
            run.cnt   = RunCntW'(2);
            phase_d   = PH_IDLE;
          end
        end
        default: begin
          if (offs < CharW'(4)) begin
            run.ev[0] = mk_ev(key_kind_e'(base + KindW'(offs[1:0])), '0);
            run.cnt   = RunCntW'(1);
          end else begin
            run.ev[0] = mk_ev(KIND_ESC, '0);
            run.ev[1] = mk_ev(KIND_PLAIN, intro);
            run.ev[2] = mk_ev(KIND_PLAIN, rx_byte_i);
            run.cnt   = RunCntW'(3);
          end
          phase_d = PH_IDLE;
          wait_d  = '0;
        end
      endcase
    end
    // Mark the final event of the run
    if (run.cnt != '0) begin
      run.ev[run.cnt - RunCntW'(1)].last = 1'b1;
    end
  end

  assign run_o = fire_i ? run : '0;

  // Advance sequence state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
    end
  end

endmodule

[hw/rtl/vt_esc_outq.sv]
// Four-entry result queue: takes a run of up to three events, sends one per beat.
module vt_esc_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vt_esc_pkg::key_run_t   run_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output vt_esc_pkg::key_ev_t    ev_o
);
  import vt_esc_pkg::*;

  localparam int unsigned Depth = 4;

  key_ev_t     mem_q [Depth];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q, cnt_d;
  logic        pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= 3'd1);
  assign pop     = valid_o & ready_i;
  assign ev_o    = mem_q[rd_q];
  assign cnt_d   = cnt_q + 3'(run_i.cnt) - 3'(pop);

  // Store the run at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RunMax; i++) begin
      if (RunCntW'(i) < run_i.cnt) begin
        mem_q[wr_q + 2'(i)] <= run_i.ev[i];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + run_i.cnt;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/vt_escape_key_decoder_top.sv]
// Top level of the terminal escape key decoder.
//
// Input stream (s_axis): one beat is a received byte in tdata or an idle tick
// flagged in tuser; a byte of 0xFF also counts as a tick. Output stream
// (m_axis): one key event per beat, kind in tuser, plain character in tdata,
// tlast on the final event caused by an input beat. Beats that cause no event
// (ticks while idle, sequence bytes mid-way) produce nothing on m_axis.
// Configuration: cfg_valid_i/cfg_data_i writes the timeout in ticks; always
// ready. Write it only while the block is idle.
//
// Each accepted beat is decoded in the same cycle and its up to three events
// land in a four-entry result queue, whose registered slots drive m_axis; the
// queue keeps events in order. One input beat is taken per cycle while the
// queue holds at most one event, so single-event traffic runs at one beat per
// cycle; a three-event run drains at one event per cycle, set by the single
// output port. When the receiver stalls, the queue fills and s_axis_tready
// drops. Reset empties the queue, returns to idle and loads a timeout of 12000.
module vt_escape_key_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] is_tick
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] char_code
  output logic [3:0]  m_axis_tuser_o,   // [3:0] key_kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import vt_esc_pkg::*;

  logic              fire;
  logic              room;
  logic [TickW-1:0]  timeout_q;
  key_run_t          run;
  key_ev_t           ev;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = room;
  assign fire            = s_axis_tvalid_i & room;

  // Hold the timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  vt_esc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .is_tick_i (s_axis_tuser_i[0]),
    .rx_byte_i (s_axis_tdata_i),
    .timeout_i (timeout_q),
    .run_o     (run)
  );

  vt_esc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .run_i   (run),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .ev_o    (ev)
  );

  assign m_axis_tdata_o = ev.code;
  assign m_axis_tuser_o = ev.kind;
  assign m_axis_tlast_o = ev.last;

endmodule

[hw/rtl/vt_esc_checker.sv]
// Port-level checks for the escape key decoder, bound to the top level.
module vt_esc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import vt_esc_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // Kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= KIND_F4)
    else $error("key kind out of range");

  // Only plain characters carry a code; non-plain events end a run or precede plain
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != KIND_PLAIN) |-> m_axis_tdata_o == '0)
    else $error("non-plain key carries a character code");

  a_key_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != KIND_PLAIN) && (m_axis_tuser_o != KIND_ESC)
      |-> m_axis_tlast_o)
    else $error("arrow or function key not last of its run");

endmodule

bind vt_escape_key_decoder_top vt_esc_checker u_vt_esc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/tb_vt_escape_key_decoder_top.sv]
// Self-checking testbench for the terminal escape key decoder top level.
`timescale 1ns / 100ps

module tb_vt_escape_key_decoder_top;
  import vt_esc_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned SettleCycles = 4;
  localparam logic [7:0] ChFiller = 8'h78;  // 'x', returns the decoder to idle

  // One input beat as it goes onto s_axis.
  typedef struct packed {
    logic       tick;
    logic [7:0] rx;
  } term_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;    // [7:0] rx_byte
  logic [0:0]  s_axis_tuser_i = '0;    // [0] is_tick
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;         // [7:0] char_code
  logic [3:0]  m_axis_tuser_o;         // [3:0] key_kind
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Stimulus and expected key events
  term_beat_t  beat_q[$];
  key_ev_t     key_exp_q[$];

  // Decoder shadow state
  phase_e      dec_phase = PH_IDLE;
  logic [15:0] dec_wait = '0;
  logic [15:0] dec_timeout = TimeoutReset;

  // Idle control and bookkeeping
  bit          in_idle_on = 1'b0;
  bit          out_idle_on = 1'b0;
  bit          in_beat_taken = 1'b0;
  int unsigned in_gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned keys_checked = 0;
  int unsigned timeouts_predicted = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned settings_used = 1;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  vt_escape_key_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 4) == 0) return $urandom_range(6, 24);
    return $urandom_range(1, 3);
  endfunction

  function automatic key_ev_t make_key(input key_kind_e kind, input logic [7:0] code);
    key_ev_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance the shadow decoder by one accepted beat and queue the key events it causes
  task automatic predict_keys(input logic tick, input logic [7:0] rx);
    key_ev_t     run[$];
    logic [16:0] limit;
    logic [7:0]  lo_char;
    logic [7:0]  intro;
    logic [7:0]  offs;
    logic [3:0]  kind_code;
    key_kind_e   base;
    limit = (dec_timeout == '0) ? 17'd1 : {1'b0, dec_timeout};
    if (tick || rx == ChNone) begin
      // Ticks only count while a sequence is open
      if (dec_phase != PH_IDLE) begin
        dec_wait = dec_wait + 16'd1;
        if ({1'b0, dec_wait} >= limit) begin
          run.push_back(make_key(KIND_ESC, '0));
          dec_phase = PH_IDLE;
          dec_wait = '0;
          timeouts_predicted++;
        end
      end
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (rx == ChEsc) begin
            dec_phase = PH_ESC;
            dec_wait = '0;
          end else begin
            run.push_back(make_key(KIND_PLAIN, rx));
          end
        end
        PH_ESC: begin
          dec_wait = '0;
          if (rx == ChCsi) begin
            dec_phase = PH_CSI;
          end else if (rx == ChSs3) begin
            dec_phase = PH_SS3;
          end else begin
            // Replay ESC and the stray byte, a second ESC included
            run.push_back(make_key(KIND_ESC, '0));
            run.push_back(make_key(KIND_PLAIN, rx));
            dec_phase = PH_IDLE;
          end
        end
        default: begin
          lo_char = (dec_phase == PH_CSI) ? ChArrowLo : ChFuncLo;
          intro = (dec_phase == PH_CSI) ? ChCsi : ChSs3;
          base = (dec_phase == PH_CSI) ? KIND_UP : KIND_F1;
          if (rx >= lo_char && rx <= lo_char + 8'd3) begin
            offs = rx - lo_char;
            kind_code = base + {2'b00, offs[1:0]};
            run.push_back(make_key(key_kind_e'(kind_code), '0));
          end else begin
            run.push_back(make_key(KIND_ESC, '0));
            run.push_back(make_key(KIND_PLAIN, intro));
            run.push_back(make_key(KIND_PLAIN, rx));
          end
          dec_phase = PH_IDLE;
          dec_wait = '0;
        end
      endcase
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) key_exp_q.push_back(run[i]);
  endtask

  // Input beat monitor, prediction and key event checks
  always @(posedge clk_i) begin
    key_ev_t exp_key;
    if (rst_ni) begin
      in_beat_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (in_beat_taken) begin
        predict_keys(s_axis_tuser_i[0], s_axis_tdata_i);
        beats_taken++;
      end else if (s_axis_tvalid_i) begin
        in_stall_cycles++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (key_exp_q.size() == 0) begin
          $error("unexpected key event: kind %0d char 0x%02h last %0b",
                 m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          fail_count++;
        end else begin
          exp_key = key_exp_q.pop_front();
          keys_checked++;
          if (m_axis_tuser_o !== exp_key.kind) begin
            $error("key_kind: expected %0d, actual %0d", exp_key.kind, m_axis_tuser_o);
            fail_count++;
          end
          if (m_axis_tdata_o !== exp_key.code) begin
            $error("char_code: expected 0x%02h, actual 0x%02h", exp_key.code, m_axis_tdata_o);
            fail_count++;
          end
          if (m_axis_tlast_o !== exp_key.last) begin
            $error("last_of_run: expected %0b, actual %0b", exp_key.last, m_axis_tlast_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Input driver: hold the beat until taken, then idle or present the next one
  always @(negedge clk_i) begin
    term_beat_t nb;
    if (s_axis_tvalid_i && !in_beat_taken) begin
      // hold
    end else if (in_gap_left > 0) begin
      in_gap_left--;
      s_axis_tvalid_i <= 1'b0;
    end else if (beat_q.size() > 0) begin
      nb = beat_q.pop_front();
      s_axis_tvalid_i <= 1'b1;
      s_axis_tuser_i <= nb.tick;
      s_axis_tdata_i <= nb.rx;
      in_gap_left = (in_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Output ready: long hold-off on request, else random stalls while out_idle_on is set
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!out_idle_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d key events still expected",
               cycle_count, key_exp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] rx);
    beat_q.push_back('{tick: 1'b0, rx: rx});
    beats_queued++;
  endtask

  // A tick either flagged in tuser with a random byte or carried as 0xFF
  task automatic push_tick();
    logic [7:0] rnd;
    rnd = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) beat_q.push_back('{tick: 1'b0, rx: ChNone});
    else beat_q.push_back('{tick: 1'b1, rx: rnd});
    beats_queued++;
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_tick();
  endtask

  // Some ticks between sequence bytes, now and then enough to time out
  task automatic push_wait_ticks();
    int unsigned eff;
    eff = (dec_timeout == '0) ? 1 : dec_timeout;
    if ($urandom_range(0, 1) == 0) begin
      // no wait
    end else if (eff <= 8) begin
      push_ticks($urandom_range(1, eff));
    end else begin
      push_ticks($urandom_range(1, 3));
    end
  endtask

  // Escape sequence with random content: well-formed most of the time
  task automatic push_key_seq();
    int unsigned pick;
    bit          csi;
    logic [7:0]  rnd;
    pick = $urandom_range(0, 99);
    csi = 1'($urandom_range(0, 1));
    rnd = 8'($urandom_range(0, 254));
    push_byte(ChEsc);
    push_wait_ticks();
    if (pick < 60) begin
      push_byte(csi ? ChCsi : ChSs3);
      push_wait_ticks();
      push_byte((csi ? ChArrowLo : ChFuncLo) + 8'($urandom_range(0, 3)));
    end else if (pick < 80) begin
      push_byte(csi ? ChCsi : ChSs3);
      push_wait_ticks();
      push_byte(rnd);
    end else begin
      push_byte(rnd);
    end
  endtask

  // Random mix of sequences and noise, closed by a byte that forces idle
  task automatic push_random_mix(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  rnd;
    start = beats_queued;
    while (beats_queued - start < n) begin
      pick = $urandom_range(0, 9);
      rnd = 8'($urandom_range(0, 255));
      if (pick < 6) push_key_seq();
      else if (pick < 8) push_byte(rnd);
      else push_tick();
    end
    push_byte(ChFiller);
  endtask

  // Wait for every beat to be taken and every key event to be checked
  task automatic drain();
    while (beats_taken != beats_queued || key_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    dec_timeout = val;
    settings_used++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every key, broken sequences, at reset timeout
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(8'hFE);
    beat_q.push_back('{tick: 1'b1, rx: ChArrowLo});  // tick while idle
    beats_queued++;
    push_byte(ChNone);                                // 0xFF while idle
    for (int i = 0; i < 4; i++) begin
      push_byte(ChEsc);
      push_byte(ChCsi);
      push_byte(ChArrowLo + 8'(i));
      push_byte(ChEsc);
      push_byte(ChSs3);
      push_byte(ChFuncLo + 8'(i));
    end
    push_byte(ChEsc);
    push_byte(ChEsc);                                 // second ESC replays as plain
    push_byte(ChEsc);
    push_byte(ChCsi);
    push_byte(ChArrowLo - 8'd1);
    push_byte(ChEsc);
    push_byte(ChSs3);
    push_byte(ChFuncLo + 8'd4);
    push_byte(ChEsc);
    push_byte(ChCsi);
    push_byte(ChNone);                                // 0xFF mid-sequence is a tick
    beat_q.push_back('{tick: 1'b1, rx: ChArrowLo});
    beats_queued++;
    push_byte(ChArrowLo + 8'd1);
    drain();

    // A few ticks under the reset timeout keep the sequence open
    push_byte(ChEsc);
    push_byte(ChCsi);
    push_ticks(5);
    push_byte(ChArrowLo);
    drain();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    push_random_mix(30);
    drain();

    // Zero timeout behaves like one tick
    write_timeout(16'h0000);
    push_byte(ChEsc);
    push_tick();
    push_byte(ChEsc);
    push_byte(ChSs3);
    push_tick();
    push_random_mix(50);
    drain();

    // Back-pressure: sender streams while the receiver holds off
    write_timeout(16'd1);
    in_idle_on = 1'b0;
    push_random_mix(50);
    hold_requests++;
    drain();

    write_timeout(16'd3);
    in_idle_on = 1'b1;
    push_random_mix(50);
    drain();

    // Largest timeout: waits between sequence bytes never expire
    write_timeout(16'hFFFF);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    push_byte(ChEsc);
    push_byte(ChSs3);
    push_ticks(4);
    push_byte(ChFuncLo + 8'd1);
    push_byte(ChEsc);
    push_ticks(4);
    push_byte(ChFiller);
    drain();

    write_timeout(16'($urandom_range(2, 6)));
    in_idle_on = 1'b1;
    push_random_mix(50);
    drain();

    write_timeout(16'd2);
    out_idle_on = 1'b1;
    push_random_mix(50);
    drain();

    $display("Covered %0d input beats and %0d key events under %0d timeout settings,",
             beats_taken, keys_checked, settings_used);
    $display("with %0d timeouts and %0d cycles of input back-pressure.",
             timeouts_predicted, in_stall_cycles);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/vt_esc_pkg.sv
hw/rtl/vt_esc_decode.sv
hw/rtl/vt_esc_outq.sv
hw/rtl/vt_escape_key_decoder_top.sv
hw/rtl/vt_esc_checker.sv
tb/tb_vt_escape_key_decoder_top.sv
